### hw/rtl/lprl_pkg.sv
package lprl_pkg;

   // item codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // scan sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int ADDR_W  = 32;
   localparam int IFACE_W = 3;
   localparam int SLOT_W  = 4;

   // one stored route
   typedef struct packed {
      logic [ADDR_W-1:0]  dest;
      logic [ADDR_W-1:0]  mask;
      logic [ADDR_W-1:0]  gateway;
      logic [IFACE_W-1:0] iface;
   } route_entry_type;

endpackage

### hw/rtl/lprl_table.sv
module lprl_table #(
   parameter int TABLE_DEPTH = 16,
   parameter int IW = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [IW-1:0]            wr_addr,
   input  logic                     wr_valid,
   input  lprl_pkg::route_entry_type wr_entry,
   input  logic                     rd_en,
   input  logic [IW-1:0]            rd_addr,
   output lprl_pkg::route_entry_type rd_entry,
   output logic                     rd_valid
);

   lprl_pkg::route_entry_type mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]    valid_ff;
   lprl_pkg::route_entry_type rd_entry_ff;
   logic                      rd_valid_ff;

   // route storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   // valid bits live in flops so reset clears them at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= wr_valid;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

### hw/rtl/lprl_scan.sv
module lprl_scan #(
   parameter int TABLE_DEPTH = 16,
   parameter int IW = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              start_addr,
   output logic                     idle,
   output logic                     rd_en,
   output logic [IW-1:0]            rd_addr,
   input  lprl_pkg::route_entry_type rd_entry,
   input  logic                     rd_valid,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic [3:0]               rsp_match_index,
   output logic [31:0]              rsp_next_hop,
   output logic [2:0]               rsp_out_iface
);

   localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

   logic [1:0]    state_ff, state_in;
   logic [31:0]   addr_ff, addr_in;
   logic [IW-1:0] issue_ff, issue_in;
   logic          issuing_ff, issuing_in;
   logic          pv_ff, pv_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic          found_ff, found_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [31:0]   best_mask_ff, best_mask_in;
   logic [31:0]   best_gw_ff, best_gw_in;
   logic [2:0]    best_iface_ff, best_iface_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [3:0]    rsp_idx_ff, rsp_idx_in;
   logic [31:0]   rsp_hop_ff, rsp_hop_in;
   logic [2:0]    rsp_iface_ff, rsp_iface_in;

   logic          match;
   logic          take;
   logic          load_rsp;
   logic [31:0]   best_idx_wide;

   // entry compare on the beat coming out of the table
   assign match = rd_valid &&
                  ((addr_ff & rd_entry.mask) == (rd_entry.dest & rd_entry.mask));
   assign take  = pv_ff && match && (!found_ff || (rd_entry.mask > best_mask_ff));

   assign best_idx_wide = 32'(best_idx_ff);
   assign load_rsp      = (state_ff == lprl_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // sequencer: issue reads slot 0 upward, compare each beat in the cycle after its read
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      issuing_in    = issuing_ff;
      pv_in         = 1'b0;
      pidx_in       = issue_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_mask_in  = best_mask_ff;
      best_gw_in    = best_gw_ff;
      best_iface_in = best_iface_ff;
      case (state_ff)
         lprl_pkg::ST_IDLE: begin
            if (start) begin
               addr_in    = start_addr;
               issue_in   = '0;
               issuing_in = 1'b1;
               found_in   = 1'b0;
               state_in   = lprl_pkg::ST_SCAN;
            end
         end
         lprl_pkg::ST_SCAN: begin
            pv_in = issuing_ff;
            if (issuing_ff) begin
               if (issue_ff == LAST) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_in = issue_ff + 1'b1;
               end
            end
            if (take) begin
               found_in      = 1'b1;
               best_idx_in   = pidx_ff;
               best_mask_in  = rd_entry.mask;
               best_gw_in    = rd_entry.gateway;
               best_iface_in = rd_entry.iface;
            end
            if (pv_ff && (pidx_ff == LAST)) begin
               state_in = lprl_pkg::ST_DONE;
            end
         end
         lprl_pkg::ST_DONE: begin
            if (load_rsp) begin
               state_in = lprl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lprl_pkg::ST_IDLE;
         end
      endcase
   end

   // output register: holds a beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_hop_in   = rsp_hop_ff;
      rsp_iface_in = rsp_iface_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = found_ff;
         if (found_ff) begin
            rsp_idx_in   = best_idx_wide[3:0];
            rsp_hop_in   = (best_gw_ff != '0) ? best_gw_ff : addr_ff;
            rsp_iface_in = best_iface_ff;
         end else begin
            rsp_idx_in   = '0;
            rsp_hop_in   = '0;
            rsp_iface_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lprl_pkg::ST_IDLE;
         issuing_ff   <= 1'b0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issuing_ff   <= issuing_in;
         pv_ff        <= pv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      issue_ff      <= issue_in;
      pidx_ff       <= pidx_in;
      best_idx_ff   <= best_idx_in;
      best_mask_ff  <= best_mask_in;
      best_gw_ff    <= best_gw_in;
      best_iface_ff <= best_iface_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_iface_ff  <= rsp_iface_in;
   end

   assign idle            = (state_ff == lprl_pkg::ST_IDLE);
   assign rd_en           = (state_ff == lprl_pkg::ST_SCAN) && issuing_ff;
   assign rd_addr         = issue_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_match_index = rsp_idx_ff;
   assign rsp_next_hop    = rsp_hop_ff;
   assign rsp_out_iface   = rsp_iface_ff;

endmodule

### hw/rtl/longest_prefix_route_lookup.sv
// Channel   Ports                                        Direction
// req       req_valid/req_ready, req_op .. lookup_addr   in:  write or lookup beat
// rsp       rsp_valid/rsp_ready, rsp_hit .. out_iface    out: one beat per lookup
//
// A write never busies the block; the next beat can be taken in the following cycle.
// A lookup reads the route memory one slot per cycle, set by the single read port of
// the memory; its result beat enters the output register once the scan has ended, and
// the next req beat is taken when that result is loaded.
// Reset clears the valid bits in flops at once; no clearing pass is needed.
// A result waits in the output register while rsp_ready is low; the block keeps
// accepting writes and a new lookup meanwhile, and a finished lookup holds until
// the output register frees up.
module longest_prefix_route_lookup #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [3:0]  req_entry_index,
   input  logic        req_entry_valid,
   input  logic [31:0] req_route_dest,
   input  logic [31:0] req_route_mask,
   input  logic [31:0] req_route_gateway,
   input  logic [2:0]  req_route_iface,
   input  logic [31:0] req_lookup_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [3:0]  rsp_match_index,
   output logic [31:0] rsp_next_hop,
   output logic [2:0]  rsp_out_iface
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic                      accept;
   logic                      scan_idle;
   logic [31:0]               slot_wide;
   logic                      wr_en;
   lprl_pkg::route_entry_type wr_entry;
   logic                      rd_en;
   logic [IW-1:0]             rd_addr;
   lprl_pkg::route_entry_type rd_entry;
   logic                      rd_valid;

   assign req_ready = scan_idle;
   assign accept    = req_valid && req_ready;

   // writes beyond the table are dropped
   assign slot_wide = 32'(req_entry_index);
   assign wr_en     = accept && (req_op == lprl_pkg::OP_WRITE) &&
                      (slot_wide < 32'(TABLE_DEPTH));

   assign wr_entry.dest    = req_route_dest;
   assign wr_entry.mask    = req_route_mask;
   assign wr_entry.gateway = req_route_gateway;
   assign wr_entry.iface   = req_route_iface;

   lprl_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IW(IW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (slot_wide[IW-1:0]),
      .wr_valid(req_entry_valid),
      .wr_entry(wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_entry(rd_entry),
      .rd_valid(rd_valid)
   );

   lprl_scan #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IW(IW)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .start          (accept && (req_op == lprl_pkg::OP_LOOKUP)),
      .start_addr     (req_lookup_addr),
      .idle           (scan_idle),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_entry       (rd_entry),
      .rd_valid       (rd_valid),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_match_index(rsp_match_index),
      .rsp_next_hop   (rsp_next_hop),
      .rsp_out_iface  (rsp_out_iface)
   );

endmodule

### hw/rtl/lprl_checker.sv
module lprl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_op,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [3:0]  rsp_match_index,
   input logic [31:0] rsp_next_hop,
   input logic [2:0]  rsp_out_iface
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_match_index) && $stable(rsp_next_hop) && $stable(rsp_out_iface))
      else $error("result beat changed while stalled");

   // a miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_match_index == 4'd0 &&
      rsp_next_hop == 32'd0 && rsp_out_iface == 3'd0)
      else $error("miss with nonzero fields");

   // a lookup occupies the scanner, so the next cycle takes no beat
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op |=> !req_ready)
      else $error("request taken during a scan");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind longest_prefix_route_lookup lprl_checker u_lprl_checker (.*);
